// ----- rtl/core/pcr_pkg.sv -----
`default_nettype none

package pcr_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COMP_W_DEFAULT = 32;
  localparam int VEC_W          = 64;
  localparam int HALF_W         = 32;
  localparam int MASS_W         = 31;
  localparam int PEN_W          = 32;
  localparam int DEN_W          = 32;
  localparam int REST_W         = 17;
  localparam int DT_W           = 16;
  localparam int CFG_DATA_W     = 17;
  localparam int CFG_IDX_W      = 1;

  localparam logic [DT_W-1:0] DT_RESET = 16'd1092;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESTITUTION = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } cfg_idx_t;

  // phase-ran flags that travel with each word
  typedef struct packed {
    logic vel;
    logic pos;
  } flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/particle_contact_resolve.sv -----
`default_nettype none

// Two-particle 2D contact resolver, one contact word per start pulse.
// Input: a word is taken at each rising edge with start high and busy low.
//   busy is high only while rst_n is low, so a word can be started every
//   cycle. Vectors are packed x in 63:32, y in 31:0, each half a signed
//   Q16.16 value in its low COMPONENT_WIDTH bits.
// Output: out_valid marks each result word for exactly one cycle; the
//   receiver takes it then and cannot stall the pipeline.
// Pipeline: the result strobe follows the input register, an 8-stage
//   velocity-target pipe, the restoring divider with one quotient bit per
//   stage plus setup and saturate stages, and a 4-stage impulse apply pipe.
// Throughput: one contact per cycle, sustained.
// Config: cfg_we writes restitution (index 0) or time_step (index 1) at
//   the edge; write only while no contact is in flight.
// Reset (synchronous, rst_n low): flushes all words in flight, sets
//   restitution to 0 and time_step to 1092.
module particle_contact_resolve import pcr_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMP_W_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VEC_W-1:0]        in_first_velocity,
  input  logic [VEC_W-1:0]        in_second_velocity,
  input  logic [VEC_W-1:0]        in_first_accel,
  input  logic [VEC_W-1:0]        in_second_accel,
  input  logic [VEC_W-1:0]        in_first_position,
  input  logic [VEC_W-1:0]        in_second_position,
  input  logic [MASS_W-1:0]       in_first_inv_mass,
  input  logic [MASS_W-1:0]       in_second_inv_mass,
  input  logic [VEC_W-1:0]        in_contact_normal,
  input  logic signed [PEN_W-1:0] in_penetration,
  output logic                    out_valid,
  output logic [VEC_W-1:0]        out_new_first_velocity,
  output logic [VEC_W-1:0]        out_new_second_velocity,
  output logic [VEC_W-1:0]        out_new_first_position,
  output logic [VEC_W-1:0]        out_new_second_position,
  output logic                    out_velocity_changed,
  output logic                    out_position_changed,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW    = COMPONENT_WIDTH;
  localparam int TAG_W = 10 * CW + 2 * MASS_W;
  localparam int DTW   = TAG_W + $bits(flags_t);

  function automatic logic signed [CW-1:0] half_of(input logic [VEC_W-1:0] w, input int h);
    return w[h*HALF_W +: CW];
  endfunction

  logic [REST_W-1:0]       rest_r;
  logic [DT_W-1:0]         dt_r;

  logic                    s0_v_r;
  logic signed [CW-1:0]    v0_r [2], v1_r [2], a0_r [2], a1_r [2];
  logic signed [CW-1:0]    p0_r [2], p1_r [2], n_r [2];
  logic [MASS_W-1:0]       m0_r, m1_r;
  logic signed [PEN_W-1:0] pen_r;
  logic [TAG_W-1:0]        tag0;

  logic                    fr_valid;
  logic signed [PEN_W-1:0] fr_num [2];
  logic signed [PEN_W-1:0] fr_imp, fr_pen;
  logic [DEN_W-1:0]        fr_den;
  flags_t                  fr_flags;
  logic [TAG_W-1:0]        fr_tag;

  logic                    dv_valid;
  logic signed [CW-1:0]    dv_quo [2];
  logic [DTW-1:0]          dv_tag;
  flags_t                  ap_flags;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= '0;
      dt_r   <= DT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RESTITUTION: rest_r <= cfg_wdata[REST_W-1:0];
        CFG_TIME_STEP:   dt_r   <= cfg_wdata[DT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      v0_r[i] <= half_of(in_first_velocity, 1 - i);
      v1_r[i] <= half_of(in_second_velocity, 1 - i);
      a0_r[i] <= half_of(in_first_accel, 1 - i);
      a1_r[i] <= half_of(in_second_accel, 1 - i);
      p0_r[i] <= half_of(in_first_position, 1 - i);
      p1_r[i] <= half_of(in_second_position, 1 - i);
      n_r[i]  <= half_of(in_contact_normal, 1 - i);
    end
    m0_r  <= in_first_inv_mass;
    m1_r  <= in_second_inv_mass;
    pen_r <= in_penetration;
  end

  assign tag0 = {v0_r[0], v0_r[1], v1_r[0], v1_r[1], p0_r[0], p0_r[1],
                 p1_r[0], p1_r[1], n_r[0], n_r[1], m0_r, m1_r};

  pcr_front #(.CW(CW), .TAG_W(TAG_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s0_v_r),
    .v0       (v0_r),
    .v1       (v1_r),
    .a0       (a0_r),
    .a1       (a1_r),
    .n        (n_r),
    .m0       (m0_r),
    .m1       (m1_r),
    .pen      (pen_r),
    .rest     (rest_r),
    .dt       (dt_r),
    .tag_in   (tag0),
    .out_valid(fr_valid),
    .num_imp  (fr_imp),
    .num_pen  (fr_pen),
    .den      (fr_den),
    .flags    (fr_flags),
    .tag_out  (fr_tag)
  );

  assign fr_num[0] = fr_imp;
  assign fr_num[1] = fr_pen;

  pcr_div #(.CW(CW), .TW(DTW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_valid),
    .num      (fr_num),
    .den      (fr_den),
    .tag      ({fr_flags, fr_tag}),
    .out_valid(dv_valid),
    .quo      (dv_quo),
    .tag_out  (dv_tag)
  );

  pcr_apply #(.CW(CW), .TAG_W(TAG_W)) u_apply (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_valid),
    .imp      (dv_quo[0]),
    .q        (dv_quo[1]),
    .flags    (dv_tag[DTW-1:TAG_W]),
    .tag      (dv_tag[TAG_W-1:0]),
    .out_valid(out_valid),
    .vel0     (out_new_first_velocity),
    .vel1     (out_new_second_velocity),
    .pos0     (out_new_first_position),
    .pos1     (out_new_second_position),
    .out_flags(ap_flags)
  );

  assign out_velocity_changed = ap_flags.vel;
  assign out_position_changed = ap_flags.pos;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(COMPONENT_WIDTH + 15) out_valid)
    else $error("result strobe missing after accepted word");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, COMPONENT_WIDTH + 15))
    else $error("result strobe without matching accepted word");

  a_mass_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_velocity_changed || out_position_changed) |->
    $past((in_first_inv_mass != '0) || (in_second_inv_mass != '0), COMPONENT_WIDTH + 15))
    else $error("phase ran with zero total inverse mass");

  a_pen_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position_changed |->
    $past(!in_penetration[PEN_W-1] && (in_penetration != '0), COMPONENT_WIDTH + 15))
    else $error("position phase ran without penetration");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pcr_front.sv -----
`default_nettype none

module pcr_front import pcr_pkg::*; #(
  parameter int CW    = COMP_W_DEFAULT,
  parameter int TAG_W = 10 * COMP_W_DEFAULT + 2 * MASS_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    v0 [2],
  input  logic signed [CW-1:0]    v1 [2],
  input  logic signed [CW-1:0]    a0 [2],
  input  logic signed [CW-1:0]    a1 [2],
  input  logic signed [CW-1:0]    n [2],
  input  logic [MASS_W-1:0]       m0,
  input  logic [MASS_W-1:0]       m1,
  input  logic signed [PEN_W-1:0] pen,
  input  logic [REST_W-1:0]       rest,
  input  logic [DT_W-1:0]         dt,
  input  logic [TAG_W-1:0]        tag_in,
  output logic                    out_valid,
  output logic signed [PEN_W-1:0] num_imp,
  output logic signed [PEN_W-1:0] num_pen,
  output logic [DEN_W-1:0]        den,
  output flags_t                  flags,
  output logic [TAG_W-1:0]        tag_out
);

  localparam int SW  = CW + 40;
  localparam int PW  = 2 * CW;
  localparam int NSW = CW + REST_W + 2;
  localparam int ACW = CW + DT_W + 1;
  localparam int AW  = CW + 1;
  localparam int RW  = AW + REST_W + 1;

  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (CW - 1));

  typedef struct packed {
    logic signed [CW-1:0]    sep;
    logic [DEN_W-1:0]        total;
    logic signed [PEN_W-1:0] pen;
    logic [TAG_W-1:0]        tag;
  } side_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [CW-1:0] r;
    if (x > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (x < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  logic [8:1]            vld_r;
  side_t                 side_r [1:8];
  side_t                 side1_nxt, side3_nxt;

  logic signed [CW-1:0]  rv_r [2], ra_r [2], n1_r [2];
  logic signed [CW-1:0]  rv_nxt [2], ra_nxt [2];
  logic signed [PW-1:0]  prv_r [2], pra_r [2];
  logic signed [PW-1:0]  prv_nxt [2], pra_nxt [2];
  logic signed [CW-1:0]  dra3_r, sep_nxt, dra_nxt;
  logic signed [NSW-1:0] nsp4_r, nsp_nxt;
  logic signed [ACW-1:0] accp4_r, accp_nxt;
  logic signed [CW-1:0]  ns5_r, ns5_nxt;
  logic signed [AW-1:0]  acc5_r, acc_nxt;
  logic signed [CW-1:0]  ns6_r;
  logic signed [RW-1:0]  racc6_r, racc_nxt;
  logic                  neg6_r;
  logic signed [CW-1:0]  sum7, ns7_r, ns7_nxt;
  logic signed [CW-1:0]  diff8_r, diff_nxt;
  flags_t                flags8_r, flags_nxt;

  always_comb begin
    side1_nxt.sep   = '0;
    side1_nxt.total = DEN_W'(m0) + DEN_W'(m1);
    side1_nxt.pen   = pen;
    side1_nxt.tag   = tag_in;
    for (int i = 0; i < 2; i++) begin
      rv_nxt[i]  = sat(SW'(v0[i]) - SW'(v1[i]));
      ra_nxt[i]  = sat(SW'(a0[i]) - SW'(a1[i]));
      prv_nxt[i] = PW'(rv_r[i]) * PW'(n1_r[i]);
      pra_nxt[i] = PW'(ra_r[i]) * PW'(n1_r[i]);
    end
    sep_nxt = sat(SW'(prv_r[0] >>> FRAC_BITS) + SW'(prv_r[1] >>> FRAC_BITS));
    dra_nxt = sat(SW'(pra_r[0] >>> FRAC_BITS) + SW'(pra_r[1] >>> FRAC_BITS));
    side3_nxt     = side_r[2];
    side3_nxt.sep = sep_nxt;
    nsp_nxt  = -NSW'($signed(side_r[3].sep)) * NSW'($signed({1'b0, rest}));
    accp_nxt = ACW'(dra3_r) * ACW'($signed({1'b0, dt}));
    ns5_nxt  = sat(SW'(nsp4_r >>> FRAC_BITS));
    acc_nxt  = AW'(accp4_r >>> FRAC_BITS);
    racc_nxt = RW'(acc5_r) * RW'($signed({1'b0, rest}));
    sum7     = sat(SW'(ns6_r) + SW'(racc6_r >>> FRAC_BITS));
    ns7_nxt  = ns6_r;
    if (neg6_r) begin
      ns7_nxt = sum7[CW-1] ? '0 : sum7;
    end
    diff_nxt      = sat(SW'(ns7_r) - SW'($signed(side_r[7].sep)));
    flags_nxt.vel = ($signed(side_r[7].sep) <= 0) && (side_r[7].total != '0);
    flags_nxt.pos = ($signed(side_r[7].pen) > 0) && (side_r[7].total != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= side1_nxt;
    side_r[2] <= side_r[1];
    side_r[3] <= side3_nxt;
    for (int k = 4; k <= 8; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int i = 0; i < 2; i++) begin
      rv_r[i]  <= rv_nxt[i];
      ra_r[i]  <= ra_nxt[i];
      n1_r[i]  <= n[i];
      prv_r[i] <= prv_nxt[i];
      pra_r[i] <= pra_nxt[i];
    end
    dra3_r   <= dra_nxt;
    nsp4_r   <= nsp_nxt;
    accp4_r  <= accp_nxt;
    ns5_r    <= ns5_nxt;
    acc5_r   <= acc_nxt;
    ns6_r    <= ns5_r;
    racc6_r  <= racc_nxt;
    neg6_r   <= acc5_r[AW-1];
    ns7_r    <= ns7_nxt;
    diff8_r  <= diff_nxt;
    flags8_r <= flags_nxt;
  end

  assign out_valid = vld_r[8];
  assign num_imp   = PEN_W'(diff8_r);
  assign num_pen   = side_r[8].pen;
  assign den       = side_r[8].total;
  assign flags     = flags8_r;
  assign tag_out   = side_r[8].tag;

endmodule

`default_nettype wire

// ----- rtl/core/pcr_div.sv -----
`default_nettype none

module pcr_div import pcr_pkg::*; #(
  parameter int CW = COMP_W_DEFAULT,
  parameter int TW = 10 * COMP_W_DEFAULT + 2 * MASS_W + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [PEN_W-1:0] num [2],
  input  logic [DEN_W-1:0]        den,
  input  logic [TW-1:0]           tag,
  output logic                    out_valid,
  output logic signed [CW-1:0]    quo [2],
  output logic [TW-1:0]           tag_out
);

  // sat(num * 2^16 / den), truncating, one quotient bit per stage
  localparam int AW = PEN_W + FRAC_BITS;
  localparam logic [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW:0]        vld_r;
  logic [DEN_W-1:0]   rem_r [CW+1][2];
  logic [CW-1:0]      bit_r [CW+1][2];
  logic [CW-1:0]      q_r   [CW+1][2];
  logic               neg_r [CW+1][2];
  logic               ovf_r [CW+1][2];
  logic [DEN_W-1:0]   den_r [CW+1];
  logic [TW-1:0]      tag_r [CW+1];

  logic [PEN_W-1:0]   mag_nxt [2];
  logic [AW-1:0]      a_nxt [2];
  logic               ovf_nxt [2];

  logic               out_v_r;
  logic [CW-1:0]      quo_r [2];
  logic [CW-1:0]      quo_nxt [2];
  logic [TW-1:0]      tag_o_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_nxt[l] = num[l][PEN_W-1] ? PEN_W'(-num[l]) : num[l];
      a_nxt[l]   = {mag_nxt[l], {FRAC_BITS{1'b0}}};
      ovf_nxt[l] = (a_nxt[l] >> CW) >= AW'(den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[CW-1:0], in_valid};
      out_v_r <= vld_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      rem_r[0][l] <= DEN_W'(a_nxt[l] >> CW);
      bit_r[0][l] <= a_nxt[l][CW-1:0];
      q_r[0][l]   <= '0;
      neg_r[0][l] <= num[l][PEN_W-1];
      ovf_r[0][l] <= ovf_nxt[l];
    end
    den_r[0] <= den;
    tag_r[0] <= tag;
  end

  for (genvar s = 0; s < CW; s++) begin : g_step
    logic [DEN_W:0] trial [2];
    logic           ge [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_r[s][l], bit_r[s][l][CW-1]};
        ge[l]    = trial[l] >= {1'b0, den_r[s]};
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[s+1][l] <= ge[l] ? DEN_W'(trial[l] - {1'b0, den_r[s]}) : trial[l][DEN_W-1:0];
        bit_r[s+1][l] <= bit_r[s][l] << 1;
        q_r[s+1][l]   <= {q_r[s][l][CW-2:0], ge[l]};
        neg_r[s+1][l] <= neg_r[s][l];
        ovf_r[s+1][l] <= ovf_r[s][l];
      end
      den_r[s+1] <= den_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_r[CW][l]) begin
        quo_nxt[l] = (ovf_r[CW][l] || (q_r[CW][l][CW-1] && (|q_r[CW][l][CW-2:0])))
                     ? QMIN : -q_r[CW][l];
      end else begin
        quo_nxt[l] = (ovf_r[CW][l] || q_r[CW][l][CW-1]) ? QMAX : q_r[CW][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      quo_r[l] <= quo_nxt[l];
    end
    tag_o_r <= tag_r[CW];
  end

  assign out_valid = out_v_r;
  assign quo[0]    = $signed(quo_r[0]);
  assign quo[1]    = $signed(quo_r[1]);
  assign tag_out   = tag_o_r;

endmodule

`default_nettype wire

// ----- rtl/core/pcr_apply.sv -----
`default_nettype none

module pcr_apply import pcr_pkg::*; #(
  parameter int CW    = COMP_W_DEFAULT,
  parameter int TAG_W = 10 * COMP_W_DEFAULT + 2 * MASS_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] imp,
  input  logic signed [CW-1:0] q,
  input  flags_t               flags,
  input  logic [TAG_W-1:0]     tag,
  output logic                 out_valid,
  output logic [VEC_W-1:0]     vel0,
  output logic [VEC_W-1:0]     vel1,
  output logic [VEC_W-1:0]     pos0,
  output logic [VEC_W-1:0]     pos1,
  output flags_t               out_flags
);

  // tag, msb first: v0 x/y, v1 x/y, p0 x/y, p1 x/y, n x/y, m0, m1
  localparam int SW = CW + 40;
  localparam int PW = 2 * CW;
  localparam int MW = CW + MASS_W + 1;

  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (CW - 1));

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [CW-1:0] r;
    if (x > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (x < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] comp_of(input logic [TAG_W-1:0] t, input int k);
    return t[TAG_W-1-k*CW -: CW];
  endfunction

  logic [3:1]            vld_r;
  logic [TAG_W-1:0]      tag_r [1:3];
  flags_t                flg_r [1:3];

  logic signed [PW-1:0]  pi_r [2], pq_r [2], pi_nxt [2], pq_nxt [2];
  logic signed [CW-1:0]  per_r [2], mv_r [2], per_nxt [2], mv_nxt [2];
  logic signed [MW-1:0]  dv0_r [2], dv1_r [2], dp0_r [2], dp1_r [2];
  logic signed [MW-1:0]  dv0_nxt [2], dv1_nxt [2], dp0_nxt [2], dp1_nxt [2];
  logic signed [MW-1:0]  m0s, m1n;
  logic signed [CW-1:0]  bv0 [2], bv1 [2], bp0 [2], bp1 [2];
  logic signed [CW-1:0]  nv0 [2], nv1 [2], np0 [2], np1 [2];
  logic [VEC_W-1:0]      vel0_nxt, vel1_nxt, pos0_nxt, pos1_nxt;

  logic                  out_v_r;
  logic [VEC_W-1:0]      vel0_r, vel1_r, pos0_r, pos1_r;
  flags_t                flags_r;

  always_comb begin
    m0s = MW'($signed({1'b0, tag_r[2][2*MASS_W-1:MASS_W]}));
    m1n = -MW'($signed({1'b0, tag_r[2][MASS_W-1:0]}));
    for (int i = 0; i < 2; i++) begin
      pi_nxt[i]  = PW'(comp_of(tag, 8 + i)) * PW'(imp);
      pq_nxt[i]  = PW'(comp_of(tag, 8 + i)) * PW'(q);
      per_nxt[i] = sat(SW'(pi_r[i] >>> FRAC_BITS));
      mv_nxt[i]  = sat(SW'(pq_r[i] >>> FRAC_BITS));
      dv0_nxt[i] = MW'(per_r[i]) * m0s;
      dv1_nxt[i] = MW'(per_r[i]) * m1n;
      dp0_nxt[i] = MW'(mv_r[i]) * m0s;
      dp1_nxt[i] = MW'(mv_r[i]) * m1n;
      bv0[i] = comp_of(tag_r[3], i);
      bv1[i] = comp_of(tag_r[3], 2 + i);
      bp0[i] = comp_of(tag_r[3], 4 + i);
      bp1[i] = comp_of(tag_r[3], 6 + i);
      nv0[i] = flg_r[3].vel ? sat(SW'(bv0[i]) + SW'(dv0_r[i] >>> FRAC_BITS)) : bv0[i];
      nv1[i] = flg_r[3].vel ? sat(SW'(bv1[i]) + SW'(dv1_r[i] >>> FRAC_BITS)) : bv1[i];
      np0[i] = flg_r[3].pos ? sat(SW'(bp0[i]) + SW'(dp0_r[i] >>> FRAC_BITS)) : bp0[i];
      np1[i] = flg_r[3].pos ? sat(SW'(bp1[i]) + SW'(dp1_r[i] >>> FRAC_BITS)) : bp1[i];
    end
    vel0_nxt = {HALF_W'(nv0[0]), HALF_W'(nv0[1])};
    vel1_nxt = {HALF_W'(nv1[0]), HALF_W'(nv1[1])};
    pos0_nxt = {HALF_W'(np0[0]), HALF_W'(np0[1])};
    pos1_nxt = {HALF_W'(np1[0]), HALF_W'(np1[1])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[2:1], in_valid};
      out_v_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    tag_r[1] <= tag;
    tag_r[2] <= tag_r[1];
    tag_r[3] <= tag_r[2];
    flg_r[1] <= flags;
    flg_r[2] <= flg_r[1];
    flg_r[3] <= flg_r[2];
    for (int i = 0; i < 2; i++) begin
      pi_r[i]  <= pi_nxt[i];
      pq_r[i]  <= pq_nxt[i];
      per_r[i] <= per_nxt[i];
      mv_r[i]  <= mv_nxt[i];
      dv0_r[i] <= dv0_nxt[i];
      dv1_r[i] <= dv1_nxt[i];
      dp0_r[i] <= dp0_nxt[i];
      dp1_r[i] <= dp1_nxt[i];
    end
    vel0_r  <= vel0_nxt;
    vel1_r  <= vel1_nxt;
    pos0_r  <= pos0_nxt;
    pos1_r  <= pos1_nxt;
    flags_r <= flg_r[3];
  end

  assign out_valid = out_v_r;
  assign vel0      = vel0_r;
  assign vel1      = vel1_r;
  assign pos0      = pos0_r;
  assign pos1      = pos1_r;
  assign out_flags = flags_r;

endmodule

`default_nettype wire

// ----- bench/particle_contact_resolve_tb.sv -----
module particle_contact_resolve_tb;
  import pcr_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = CW + 14;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [VEC_W-1:0]  v0, v1, a0, a1, p0, p1, nrm;
    logic [MASS_W-1:0] m0, m1;
    logic [PEN_W-1:0]  pen;
  } contact_t;

  typedef struct {
    logic [VEC_W-1:0] v0, v1, p0, p1;
    logic             vch, pch;
  } resolved_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VEC_W-1:0] in_v0 = '0, in_v1 = '0, in_a0 = '0, in_a1 = '0;
  logic [VEC_W-1:0] in_p0 = '0, in_p1 = '0, in_nrm = '0;
  logic [MASS_W-1:0] in_m0 = '0, in_m1 = '0;
  logic signed [PEN_W-1:0] in_pen = '0;
  logic out_valid;
  logic [VEC_W-1:0] out_v0, out_v1, out_p0, out_p1;
  logic out_vch, out_pch;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  longint restitution_q = 0;
  longint time_step_q = 1092;

  contact_t  pending_contacts[$];
  resolved_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  particle_contact_resolve #(.COMPONENT_WIDTH(CW)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_velocity(in_v0), .in_second_velocity(in_v1),
    .in_first_accel(in_a0), .in_second_accel(in_a1),
    .in_first_position(in_p0), .in_second_position(in_p1),
    .in_first_inv_mass(in_m0), .in_second_inv_mass(in_m1),
    .in_contact_normal(in_nrm), .in_penetration(in_pen),
    .out_valid(out_valid),
    .out_new_first_velocity(out_v0), .out_new_second_velocity(out_v1),
    .out_new_first_position(out_p0), .out_new_second_position(out_p1),
    .out_velocity_changed(out_vch), .out_position_changed(out_pch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat(longint x);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint half_of(logic [VEC_W-1:0] p, int hi_half);
    logic [CW-1:0] h;
    h = hi_half ? p[32 +: CW] : p[0 +: CW];
    return longint'($signed(h));
  endfunction

  function automatic logic [VEC_W-1:0] join_halves(longint x, longint y);
    logic [31:0] hx, hy;
    hx = x[31:0];
    hy = y[31:0];
    return {hx, hy};
  endfunction

  function automatic longint dot2(longint ux, longint uy, longint nx, longint ny);
    return sat(((ux * nx) >>> FRAC_BITS) + ((uy * ny) >>> FRAC_BITS));
  endfunction

  function automatic resolved_t resolve_contact(contact_t c);
    resolved_t r;
    longint v0[2], v1[2], a0[2], a1[2], p0[2], p1[2], n[2], rv[2], ra[2];
    longint m0, m1, total, pen, sep, ns, acc, imp, per, q, mv;
    for (int i = 0; i < 2; i++) begin
      v0[i] = half_of(c.v0, 1 - i);
      v1[i] = half_of(c.v1, 1 - i);
      a0[i] = half_of(c.a0, 1 - i);
      a1[i] = half_of(c.a1, 1 - i);
      p0[i] = half_of(c.p0, 1 - i);
      p1[i] = half_of(c.p1, 1 - i);
      n[i]  = half_of(c.nrm, 1 - i);
      rv[i] = sat(v0[i] - v1[i]);
      ra[i] = sat(a0[i] - a1[i]);
    end
    m0 = longint'(c.m0);
    m1 = longint'(c.m1);
    total = m0 + m1;
    pen = longint'($signed(c.pen));
    r.vch = 1'b0;
    r.pch = 1'b0;
    sep = dot2(rv[0], rv[1], n[0], n[1]);
    if (sep <= 0 && total > 0) begin
      ns = sat((-sep * restitution_q) >>> FRAC_BITS);
      acc = (dot2(ra[0], ra[1], n[0], n[1]) * time_step_q) >>> FRAC_BITS;
      if (acc < 0) begin
        ns = sat(ns + ((restitution_q * acc) >>> FRAC_BITS));
        if (ns < 0) ns = 0;
      end
      imp = sat(sat(ns - sep) * 65536 / total);
      for (int i = 0; i < 2; i++) begin
        per = sat((n[i] * imp) >>> FRAC_BITS);
        v0[i] = sat(v0[i] + ((per * m0) >>> FRAC_BITS));
        v1[i] = sat(v1[i] + ((per * -m1) >>> FRAC_BITS));
      end
      r.vch = 1'b1;
    end
    if (pen > 0 && total > 0) begin
      q = sat(pen * 65536 / total);
      for (int i = 0; i < 2; i++) begin
        mv = sat((n[i] * q) >>> FRAC_BITS);
        p0[i] = sat(p0[i] + ((mv * m0) >>> FRAC_BITS));
        p1[i] = sat(p1[i] + ((mv * -m1) >>> FRAC_BITS));
      end
      r.pch = 1'b1;
    end
    r.v0 = join_halves(v0[0], v0[1]);
    r.v1 = join_halves(v1[0], v1[1]);
    r.p0 = join_halves(p0[0], p0[1]);
    r.p1 = join_halves(p1[0], p1[1]);
    return r;
  endfunction

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    contact_t c;
    logic go;
    go = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        c = pending_contacts.pop_front();
        expected_results.push_back(resolve_contact(c));
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_contacts.size() > 0) begin
        go = 1'b1;
        c = pending_contacts[0];
        in_v0 <= c.v0; in_v1 <= c.v1; in_a0 <= c.a0; in_a1 <= c.a1;
        in_p0 <= c.p0; in_p1 <= c.p1; in_nrm <= c.nrm;
        in_m0 <= c.m0; in_m1 <= c.m1; in_pen <= c.pen;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 5);
        end
      end
    end
    start <= go;
  end

  // monitor
  always @(posedge clk) begin
    resolved_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_v0 !== e.v0) begin
          $error("new_first_velocity exp %h got %h", e.v0, out_v0); errors++;
        end
        if (out_v1 !== e.v1) begin
          $error("new_second_velocity exp %h got %h", e.v1, out_v1); errors++;
        end
        if (out_p0 !== e.p0) begin
          $error("new_first_position exp %h got %h", e.p0, out_p0); errors++;
        end
        if (out_p1 !== e.p1) begin
          $error("new_second_position exp %h got %h", e.p1, out_p1); errors++;
        end
        if (out_vch !== e.vch) begin
          $error("velocity_changed exp %0b got %0b", e.vch, out_vch); errors++;
        end
        if (out_pch !== e.pch) begin
          $error("position_changed exp %0b got %0b", e.pch, out_pch); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return 32'h0;
      default: return 32'($signed($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec();
    return {rand_comp(), rand_comp()};
  endfunction

  function automatic logic [VEC_W-1:0] rand_normal();
    case ($urandom_range(0, 7))
      0: return {32'sd65536, 32'sd0};
      1: return {32'sd0, -32'sd65536};
      2: return {32'sd46341, -32'sd46341};
      3: return {-32'sd39322, 32'sd52429};
      4: return {$urandom, $urandom};
      default: return {32'($signed($urandom_range(0, 131072)) - 65536),
                       32'($signed($urandom_range(0, 131072)) - 65536)};
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] rand_mass();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MASS_W'($urandom);
      3: return 31'd1;
      default: return MASS_W'($urandom_range(1, 262144));
    endcase
  endfunction

  function automatic logic [PEN_W-1:0] rand_pen();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return 32'h0;
      4: return 32'($signed($urandom_range(0, 65536)) - 65536);
      default: return 32'($urandom_range(1, 131072));
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.v0 = rand_vec(); c.v1 = rand_vec();
    c.a0 = rand_vec(); c.a1 = rand_vec();
    c.p0 = rand_vec(); c.p1 = rand_vec();
    c.nrm = rand_normal();
    c.m0 = rand_mass(); c.m1 = rand_mass();
    c.pen = rand_pen();
    if ($urandom_range(0, 5) == 0) begin
      c.m1 = '0; c.v1 = '0; c.a1 = '0;
    end
    return c;
  endfunction

  task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_RESTITUTION) restitution_q = longint'(val);
    else time_step_q = longint'(val[DT_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_contacts.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  initial begin
    contact_t c;
    logic [CFG_DATA_W-1:0] rests[6];
    logic [CFG_DATA_W-1:0] steps[6];
    rests = '{17'd52429, 17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd0};
    steps = '{16'd1092, 16'd65535, 16'd0, 16'd1092, 16'd16384, 16'd0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under reset config
    for (int k = 0; k < 20; k++) begin
      c = rand_contact();
      c.nrm = {32'sd65536, 32'sd0};
      c.m0 = 31'd65536; c.m1 = 31'd65536;
      case (k)
        0: begin c.v0 = {32'sd65536, 32'sd0}; c.v1 = {-32'sd65536, 32'sd0}; end
        1: begin c.v0 = {-32'sd65536, 32'sd0}; c.v1 = '0; end
        2: begin c.v0 = '0; c.v1 = '0; c.a0 = '0; c.a1 = '0; end
        3: begin c.m0 = '0; c.m1 = '0; c.pen = 32'sd65536; end
        4: begin c.pen = 32'sd0; end
        5: begin c.pen = -32'sd100; end
        6: begin c.pen = 32'h7fffffff; c.m0 = 31'd1; c.m1 = '0; end
        7: begin c.m1 = '0; c.v1 = '0; c.a1 = '0; end
        8: begin c.v0 = {32'h80000000, 32'h80000000}; c.v1 = {32'h7fffffff, 32'h7fffffff};
                 c.m0 = '1; c.m1 = '1; end
        9: begin c.a0 = {32'h80000000, 32'h0}; c.a1 = {32'h7fffffff, 32'h0};
                 c.v0 = {-32'sd100, 32'sd0}; c.v1 = '0; end
        10: begin c.nrm = {32'hffffffff, 32'hffffffff}; end
        default: ;
      endcase
      pending_contacts.push_back(c);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_RESTITUTION, ph == 5 ? CFG_DATA_W'($urandom_range(0, 65536)) : rests[ph]);
      write_cfg(CFG_TIME_STEP, ph == 5 ? CFG_DATA_W'($urandom_range(0, 65535)) : steps[ph]);
      for (int k = 0; k < 175; k++) pending_contacts.push_back(rand_contact());
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pcr_pkg.sv
rtl/core/pcr_front.sv
rtl/core/pcr_div.sv
rtl/core/pcr_apply.sv
rtl/core/particle_contact_resolve.sv
bench/particle_contact_resolve_tb.sv
